// ===== rtl/ring_cache_with_expiry_core_assert.svh =====
// Assertion macros for the ring cache core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef RING_CACHE_WITH_EXPIRY_CORE_ASSERT_SVH
`define RING_CACHE_WITH_EXPIRY_CORE_ASSERT_SVH

// same-cycle implication
`define RCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rce_pkg.sv =====
// Shared constants, operation codes and controller/datapath structs
// for the ring cache core. No dependencies.
package rce_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int TMO_BITS   = 16;
  localparam int TIME_BITS  = 32;
  localparam int CNT_BITS   = 32;
  localparam int KIND_BITS  = 3;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int CAP_W      = $clog2(DEPTH + 1);

  localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

  localparam logic [KIND_BITS-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_GET    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_TICK   = 3'd4;

  typedef struct packed {
    logic load;    // latch the input word
    logic apply;   // add / clear / tick, and arm the slot walk
    logic issue;   // read one slot and advance the walk
    logic finish;  // update counters and load the result word
  } rce_cmd_t;

  typedef struct packed {
    logic last_issue;  // slot being issued is the last of the walk
    logic out_free;    // result register can take a word this cycle
  } rce_sts_t;

endpackage

// ===== rtl/rce_ctrl.sv =====
// Sequencer for the ring cache core: accept, apply, walk the slots, finish.
// Depends on rce_pkg for the command and status structs.
module rce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rce_pkg::rce_sts_t sts_i,
  output rce_pkg::rce_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPLY  = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last slot is evaluated here
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rce_dp.sv =====
// Datapath for the ring cache core: slot memories, valid bits, head,
// clock, hit/miss counters, slot walk and result register. Uses rce_pkg.
module rce_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rce_pkg::rce_cmd_t                   cmd_i,
  output rce_pkg::rce_sts_t                   sts_o,
  input  logic                                cfg_valid_i,
  input  logic [rce_pkg::CAP_W-1:0]           cfg_capacity_i,
  input  logic [rce_pkg::KIND_BITS-1:0]       kind_i,
  input  logic [rce_pkg::KEY_BITS-1:0]        key_i,
  input  logic [rce_pkg::VALUE_BITS-1:0]      value_i,
  input  logic [rce_pkg::TMO_BITS-1:0]        timeout_seconds_i,
  input  logic                                never_expires_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                found_o,
  output logic [rce_pkg::VALUE_BITS-1:0]      found_value_o,
  output logic [rce_pkg::CNT_BITS-1:0]        hit_count_o,
  output logic [rce_pkg::CNT_BITS-1:0]        miss_count_o,
  output logic [rce_pkg::CAP_W-1:0]           live_entries_o
);

  // slot memories
  logic [rce_pkg::KEY_BITS-1:0]   key_mem [rce_pkg::DEPTH];
  logic [rce_pkg::VALUE_BITS-1:0] val_mem [rce_pkg::DEPTH];
  logic [rce_pkg::TIME_BITS-1:0]  exp_mem [rce_pkg::DEPTH];
  logic                           fwd_mem [rce_pkg::DEPTH];

  logic [rce_pkg::DEPTH-1:0]      valid_q;
  logic [rce_pkg::SLOT_W-1:0]     head_q;
  logic [rce_pkg::TIME_BITS-1:0]  now_q;
  logic [rce_pkg::CNT_BITS-1:0]   hits_q, hits_d;
  logic [rce_pkg::CNT_BITS-1:0]   misses_q, misses_d;
  logic [rce_pkg::CAP_W-1:0]      cap_q;

  // latched input word
  logic [rce_pkg::KIND_BITS-1:0]  kind_q;
  logic [rce_pkg::KEY_BITS-1:0]   key_q;
  logic [rce_pkg::VALUE_BITS-1:0] value_q;
  logic [rce_pkg::TMO_BITS-1:0]   tmo_q;
  logic                           fwd_q;

  // walk and evaluation stage
  logic [rce_pkg::SLOT_W-1:0]     rd_idx_q;
  logic [rce_pkg::CAP_W-1:0]      walk_cnt_q;
  logic                           ev_v_q;
  logic [rce_pkg::SLOT_W-1:0]     ev_idx_q;
  logic [rce_pkg::KEY_BITS-1:0]   key_rd_q;
  logic [rce_pkg::VALUE_BITS-1:0] val_rd_q;
  logic [rce_pkg::TIME_BITS-1:0]  exp_rd_q;
  logic                           fwd_rd_q;
  logic                           found_q;
  logic [rce_pkg::VALUE_BITS-1:0] fval_q;
  logic [rce_pkg::CAP_W-1:0]      live_q;
  logic                           out_valid_q;

  logic [rce_pkg::CAP_W-1:0]      cap_w, cap_m1, head_nx;
  logic [rce_pkg::SLOT_W-1:0]     head_d, start_idx, rd_idx_nx;
  logic [rce_pkg::TIME_BITS:0]    exp_sum;
  logic [rce_pkg::TIME_BITS-1:0]  exp_new;
  logic                           ev_live, ev_match;
  logic                           is_add, is_get, is_rem;

  assign is_add = (kind_q == rce_pkg::KIND_ADD);
  assign is_get = (kind_q == rce_pkg::KIND_GET);
  assign is_rem = (kind_q == rce_pkg::KIND_REMOVE);

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_w = rce_pkg::CAP_W'(1);
    end else if (cap_q > rce_pkg::DEPTH_C) begin
      cap_w = rce_pkg::DEPTH_C;
    end else begin
      cap_w = cap_q;
    end
  end

  assign cap_m1  = cap_w - rce_pkg::CAP_W'(1);
  assign head_nx = {1'b0, head_q} + rce_pkg::CAP_W'(1);
  assign head_d  = (head_nx >= cap_w) ? '0 : head_nx[rce_pkg::SLOT_W-1:0];

  // search starts at head, or at the top slot if capacity shrank below it
  assign start_idx = ({1'b0, head_q} < cap_w) ? head_q : cap_m1[rce_pkg::SLOT_W-1:0];
  assign rd_idx_nx = (rd_idx_q == '0) ? cap_m1[rce_pkg::SLOT_W-1:0]
                                      : rd_idx_q - rce_pkg::SLOT_W'(1);

  assign exp_sum = {1'b0, now_q} + (rce_pkg::TIME_BITS + 1)'(tmo_q);
  assign exp_new = exp_sum[rce_pkg::TIME_BITS] ? '1 : exp_sum[rce_pkg::TIME_BITS-1:0];

  assign ev_live  = valid_q[ev_idx_q] && (fwd_rd_q || (exp_rd_q > now_q));
  assign ev_match = ev_live && (key_rd_q == key_q);

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (cmd_i.finish && is_get) begin
      if (found_q) begin
        if (hits_q != '1) hits_d = hits_q + rce_pkg::CNT_BITS'(1);
      end else begin
        if (misses_q != '1) misses_d = misses_q + rce_pkg::CNT_BITS'(1);
      end
    end
  end

  assign sts_o.last_issue = (walk_cnt_q == cap_m1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && is_add) begin
      key_mem[head_d] <= key_q;
      val_mem[head_d] <= value_q;
      exp_mem[head_d] <= exp_new;
      fwd_mem[head_d] <= fwd_q;
    end
    if (cmd_i.issue) begin
      key_rd_q <= key_mem[rd_idx_q];
      val_rd_q <= val_mem[rd_idx_q];
      exp_rd_q <= exp_mem[rd_idx_q];
      fwd_rd_q <= fwd_mem[rd_idx_q];
      ev_idx_q <= rd_idx_q;
    end
  end

  // input word and walk accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
      tmo_q   <= timeout_seconds_i;
      fwd_q   <= never_expires_i;
    end
    if (cmd_i.apply) begin
      found_q <= 1'b0;
      fval_q  <= '0;
      live_q  <= '0;
    end else if (ev_v_q) begin
      if (is_get && !found_q && ev_match) begin
        found_q <= 1'b1;
        fval_q  <= val_rd_q;
      end
      // a removed slot no longer counts
      if (ev_live && !(is_rem && ev_match)) live_q <= live_q + rce_pkg::CAP_W'(1);
    end
    if (cmd_i.finish) begin
      found_o        <= found_q;
      found_value_o  <= fval_q;
      hit_count_o    <= hits_d;
      miss_count_o   <= misses_d;
      live_entries_o <= live_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      head_q      <= '0;
      now_q       <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      cap_q       <= rce_pkg::DEPTH_C;
      rd_idx_q    <= '0;
      walk_cnt_q  <= '0;
      ev_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_capacity_i;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      ev_v_q   <= cmd_i.issue;
      if (cmd_i.apply) begin
        rd_idx_q   <= start_idx;
        walk_cnt_q <= '0;
        case (kind_q)
          rce_pkg::KIND_ADD: begin
            head_q          <= head_d;
            valid_q[head_d] <= 1'b1;
          end
          rce_pkg::KIND_CLEAR: begin
            valid_q <= '0;
          end
          rce_pkg::KIND_TICK: begin
            if (now_q != '1) now_q <= now_q + rce_pkg::TIME_BITS'(1);
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.issue) begin
        rd_idx_q   <= rd_idx_nx;
        walk_cnt_q <= walk_cnt_q + rce_pkg::CAP_W'(1);
      end
      // drop every live match on remove
      if (ev_v_q && is_rem && ev_match) valid_q[ev_idx_q] <= 1'b0;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ring_cache_with_expiry_core.sv =====
// Top level of the ring cache core: sequencer plus datapath.
// Depends on rce_pkg, rce_ctrl, rce_dp and the assertion macro header.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | input     | in_valid_i/in_ready_o  | kind, key, value, timeout, never
//   out      | output    | out_valid_o/out_ready_i| found, value, hits, misses, live
//   cfg      | input     | cfg_valid_i/cfg_ready_o| capacity
//
// Each word is accepted, applied, walked over the slot memories, drained and finished;
// the walk reads one slot per cycle over the capacity in use.
// One word is in flight at a time; the next is accepted once the result is loaded.
// Reset clears valid bits, head, clock and counters and sets capacity to 16.
// A result held by out_ready_i low stalls the next word in its finish state.
module ring_cache_with_expiry_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rce_pkg::CAP_W-1:0]       cfg_capacity_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rce_pkg::KIND_BITS-1:0]   kind_i,
  input  logic [rce_pkg::KEY_BITS-1:0]    key_i,
  input  logic [rce_pkg::VALUE_BITS-1:0]  value_i,
  input  logic [rce_pkg::TMO_BITS-1:0]    timeout_seconds_i,
  input  logic                            never_expires_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [rce_pkg::VALUE_BITS-1:0]  found_value_o,
  output logic [rce_pkg::CNT_BITS-1:0]    hit_count_o,
  output logic [rce_pkg::CNT_BITS-1:0]    miss_count_o,
  output logic [rce_pkg::CAP_W-1:0]       live_entries_o
);

`include "ring_cache_with_expiry_core_assert.svh"

  rce_pkg::rce_cmd_t cmd;
  rce_pkg::rce_sts_t sts;

  // capacity register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  rce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rce_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_capacity_i    (cfg_capacity_i),
    .kind_i            (kind_i),
    .key_i             (key_i),
    .value_i           (value_i),
    .timeout_seconds_i (timeout_seconds_i),
    .never_expires_i   (never_expires_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .found_o           (found_o),
    .found_value_o     (found_value_o),
    .hit_count_o       (hit_count_o),
    .miss_count_o      (miss_count_o),
    .live_entries_o    (live_entries_o)
  );

  `RCE_ASSERT_NOW(a_live_bound, out_valid_o, live_entries_o <= rce_pkg::DEPTH_C, "live too big")
  `RCE_ASSERT_NOW(a_miss_value, out_valid_o && !found_o, found_value_o == '0, "value on a miss")
  `RCE_ASSERT_NOW(a_hit_counted, out_valid_o && found_o, hit_count_o != '0, "hit not counted")
  `RCE_ASSERT_NXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o, "word taken while busy")
  `RCE_ASSERT_NOW(a_finish_free, cmd.finish, sts.out_free, "result loaded over a held word")

endmodule

// ===== tb/sv/ring_cache_with_expiry_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for ring_cache_with_expiry_core: drives cache words and capacity writes,
// mirrors the cache in a small class and checks every result word against it.
// Depends on rce_pkg and the ring_cache_with_expiry_core RTL.
module ring_cache_with_expiry_core_tb;
  import rce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WORDS_PER_PHASE = 155;
  localparam int unsigned IDLE_PERCENT = 18;
  localparam logic [KIND_BITS-1:0] KIND_SPARE_FIRST = KIND_TICK + 1'b1;
  localparam logic [KIND_BITS-1:0] KIND_LAST = '1;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [TMO_BITS-1:0]   tmo;
    logic                  never;
  } cache_word_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_BITS-1:0]   hits;
    logic [CNT_BITS-1:0]   misses;
    logic [CAP_W-1:0]      live;
  } cache_result_t;

  // Shadow copy of the ring cache plus the queue of results it predicts.
  class cache_shadow;
    logic [KEY_BITS-1:0]   slot_key[DEPTH];
    logic [VALUE_BITS-1:0] slot_value[DEPTH];
    logic [TIME_BITS-1:0]  slot_expiry[DEPTH];
    bit                    slot_forever[DEPTH];
    bit                    slot_valid[DEPTH];
    int unsigned           head;
    logic [CNT_BITS-1:0]   hits;
    logic [CNT_BITS-1:0]   misses;
    logic [TIME_BITS-1:0]  now_s;
    logic [CAP_W-1:0]      capacity;
    cache_result_t         pending_results[$];
    int unsigned           errors;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      head = 0;
      hits = '0;
      misses = '0;
      now_s = '0;
      capacity = DEPTH_C;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned slots_in_use();
      if (capacity == 0) return 1;
      if (capacity > DEPTH) return DEPTH;
      return 32'(capacity);
    endfunction

    function bit is_live(int unsigned s);
      return slot_valid[s] && (slot_forever[s] || slot_expiry[s] > now_s);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_word(cache_word_t w);
      int unsigned cap;
      int unsigned s;
      logic [TIME_BITS:0] sum;
      cache_result_t r;
      cap = slots_in_use();
      r = '0;
      case (w.kind)
        KIND_ADD: begin
          s = head + 1;
          if (s >= cap) s = 0;
          head = s;
          slot_key[s] = w.key;
          slot_value[s] = w.value;
          slot_forever[s] = w.never;
          sum = {1'b0, now_s} + (TIME_BITS + 1)'(w.tmo);
          slot_expiry[s] = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
          slot_valid[s] = 1'b1;
        end
        KIND_GET: begin
          // walk newest first, backwards with wrap
          s = (head < cap) ? head : cap - 1;
          for (int i = 0; i < cap; i++) begin
            if (is_live(s) && slot_key[s] == w.key) begin
              r.found = 1'b1;
              r.value = slot_value[s];
              break;
            end
            s = (s == 0) ? cap - 1 : s - 1;
          end
          if (r.found) begin
            if (hits != '1) hits++;
          end else begin
            if (misses != '1) misses++;
          end
        end
        KIND_REMOVE: begin
          for (int i = 0; i < cap; i++)
            if (is_live(i) && slot_key[i] == w.key) slot_valid[i] = 1'b0;
        end
        KIND_CLEAR: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        end
        KIND_TICK: begin
          if (now_s != '1) now_s++;
        end
        default: ;
      endcase
      r.hits = hits;
      r.misses = misses;
      for (int i = 0; i < cap; i++)
        if (is_live(i)) r.live++;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("found_value", 32'(want.value), 32'(got.value));
      compare_field("hit_count", 32'(want.hits), 32'(got.hits));
      compare_field("miss_count", 32'(want.misses), 32'(got.misses));
      compare_field("live_entries", 32'(want.live), 32'(got.live));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready_o;
  logic [CAP_W-1:0]      cfg_capacity;
  logic                  in_valid;
  logic                  in_ready_o;
  cache_word_t           in_word;
  logic                  out_valid_o;
  logic                  out_ready;
  logic                  found_o;
  logic [VALUE_BITS-1:0] found_value_o;
  logic [CNT_BITS-1:0]   hit_count_o;
  logic [CNT_BITS-1:0]   miss_count_o;
  logic [CAP_W-1:0]      live_entries_o;

  cache_shadow           shadow = new();
  bit                    idle_on = 1'b1;
  int unsigned           rx_hold = 0;
  int unsigned           cycle_count = 0;
  logic [KEY_BITS-1:0]   key_pool[8];
  logic [CAP_W-1:0]      cap_plan[9];

  ring_cache_with_expiry_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_capacity_i    (cfg_capacity),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .kind_i            (in_word.kind),
    .key_i             (in_word.key),
    .value_i           (in_word.value),
    .timeout_seconds_i (in_word.tmo),
    .never_expires_i   (in_word.never),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .found_o           (found_o),
    .found_value_o     (found_value_o),
    .hit_count_o       (hit_count_o),
    .miss_count_o      (miss_count_o),
    .live_entries_o    (live_entries_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic cache_word_t word(logic [KIND_BITS-1:0] kind, logic [KEY_BITS-1:0] key,
                                       logic [VALUE_BITS-1:0] value,
                                       logic [TMO_BITS-1:0] tmo, logic never);
    cache_word_t w;
    w.kind = kind;
    w.key = key;
    w.value = value;
    w.tmo = tmo;
    w.never = never;
    return w;
  endfunction

  function automatic cache_word_t random_word();
    cache_word_t w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 34) w.kind = KIND_ADD;
    else if (r < 66) w.kind = KIND_GET;
    else if (r < 74) w.kind = KIND_REMOVE;
    else if (r < 77) w.kind = KIND_CLEAR;
    else if (r < 93) w.kind = KIND_TICK;
    else w.kind = KIND_SPARE_FIRST + KIND_BITS'($urandom_range(KIND_LAST - KIND_SPARE_FIRST));
    // mostly a small key set so gets and removes find something
    w.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : $urandom();
    w.value = $urandom();
    r = $urandom_range(99);
    if (r < 70) w.tmo = TMO_BITS'($urandom_range(12));
    else if (r < 90) w.tmo = TMO_BITS'($urandom());
    else w.tmo = r[0] ? '1 : '0;
    w.never = ($urandom_range(99) < 25);
    return w;
  endfunction

  // Returns at the accepting edge with valid still high; the caller drives the next step.
  task automatic send_word(cache_word_t w);
    int unsigned gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_word(w);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    while (shadow.pending() != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    shadow.set_capacity(cap);
  endtask

  task automatic run_random_phase(int unsigned count, bit with_hold);
    for (int unsigned i = 0; i < count; i++) begin
      // stall the receiver long enough to back up the input
      if (with_hold && i == 40) rx_hold = HOLD_OFF_CYCLES;
      send_word(random_word());
    end
    stop_input();
  endtask

  // result side: sample at the edge, then pick the next ready
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready)
        shadow.check_result({found_o, found_value_o, hit_count_o, miss_count_o,
                             live_entries_o});
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_capacity <= '0;
    in_valid <= 1'b0;
    in_word <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
    cap_plan = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd16, 5'd17, 5'd2, 5'd0, 5'd16};
    cap_plan[7] = CAP_W'($urandom_range(15, 4));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset capacity
    send_word(word(KIND_GET, '0, '0, '0, 1'b0));
    send_word(word(KIND_ADD, '0, '1, '0, 1'b1));
    send_word(word(KIND_ADD, '1, '0, '0, 1'b0));        // expires on arrival
    send_word(word(KIND_ADD, 32'h1, 32'h1, 16'h1, 1'b0));
    send_word(word(KIND_ADD, '0, 32'h1234_5678, '1, 1'b0));
    send_word(word(KIND_GET, '0, '0, '0, 1'b0));        // newest duplicate wins
    send_word(word(KIND_GET, '1, '0, '0, 1'b0));
    send_word(word(KIND_GET, 32'h1, '1, '1, 1'b1));
    send_word(word(KIND_TICK, '1, '1, '1, 1'b1));
    send_word(word(KIND_GET, 32'h1, '0, '0, 1'b0));     // now expired
    send_word(word(KIND_REMOVE, '0, '0, '0, 1'b0));
    send_word(word(KIND_GET, '0, '0, '0, 1'b0));
    for (logic [KIND_BITS:0] k = {1'b0, KIND_SPARE_FIRST}; k <= {1'b0, KIND_LAST}; k++)
      send_word(word(k[KIND_BITS-1:0], '1, '1, '1, 1'b1));
    send_word(word(KIND_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 16'h8000, 1'b0));
    send_word(word(KIND_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 16'h7FFF, 1'b1));
    send_word(word(KIND_CLEAR, '0, '0, '0, 1'b0));
    send_word(word(KIND_GET, 32'hAAAA_AAAA, '0, '0, 1'b0));
    send_word(word(KIND_ADD, 32'h2, 32'h2, 16'h3, 1'b0));
    send_word(word(KIND_ADD, 32'h3, 32'h3, '0, 1'b1));
    send_word(word(KIND_ADD, 32'h4, 32'h4, 16'h2, 1'b0));
    send_word(word(KIND_GET, 32'h3, '0, '0, 1'b0));
    send_word(word(KIND_REMOVE, '1, '0, '0, 1'b0));
    stop_input();

    // shrinking to three leaves the head past the ring end
    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      idle_on = (p != 4);
      run_random_phase(WORDS_PER_PHASE, p == 0);
    end

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
